FILE: design/sli_pkg.sv
// ============================================================================
// sli_pkg: shared types and constants for the sorted list core
// Field widths, operation and status codes, and the record that one list
// cell holds and hands to its neighbors.
// ============================================================================
package sli_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int ID_W     = 31;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Operation that every cell performs in the current cycle.
    typedef enum logic [2:0] {
        CMD_HOLD = 3'd0,
        CMD_CMP  = 3'd1,
        CMD_INS  = 3'd2,
        CMD_DEL  = 3'd3,
        CMD_ROT  = 3'd4
    } t_cell_cmd;

    typedef struct packed {
        logic                    occ;
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
    } t_entry;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      left_ge;     // every cell to the left holds a key >= the new key
        logic      hit_before;  // some cell to the left matched the searched id
    } t_cell_ctl;

endpackage

FILE: design/sorted_list_insert_delete_core.sv
// ============================================================================
// sorted_list_insert_delete_core: bounded list kept in descending key order
// A row of CAPACITY cells compares in the compare state and shifts in the execute state.
// ============================================================================
// Insert and delete: a compare state, then an execute state that, once the output
// is free, registers the result, updates the cells and can accept the next item.
// Dump: one result a cycle from the head while the output is free, as the cells
// rotate the list once around; an empty list gives a single EMPTY result.
// Reset (synchronous, active low) empties the list at once.
module sorted_list_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sli_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [sli_pkg::KEY_W-1:0] i_key,
    input  logic [sli_pkg::ID_W-1:0]         i_item_id,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sli_pkg::STATUS_W-1:0]     o_status,
    output logic signed [sli_pkg::KEY_W-1:0] o_out_key,
    output logic [sli_pkg::ID_W-1:0]         o_out_id,
    output logic [sli_pkg::POS_W-1:0]        o_position,
    output logic                             o_last
);
    import sli_pkg::*;

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_EXEC = 4'b0100,
        S_DUMP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [MODE_W-1:0]       r_mode;
    logic signed [KEY_W-1:0] r_key;
    logic [ID_W-1:0]         r_id;
    logic [CNTW-1:0]         r_count, n_count;
    logic [CNTW-1:0]         r_dump_idx, n_dump_idx;

    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic signed [KEY_W-1:0] r_out_key, n_out_key;
    logic [ID_W-1:0]         r_out_id, n_out_id;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_last, n_last;
    logic                    w_load;

    t_entry                  w_ent [CAPACITY];
    t_cell_ctl               w_ctl [CAPACITY];
    logic [CAPACITY-1:0]     w_ge, w_hit, w_first, w_ins, w_before, w_occ;
    t_cell_cmd               w_cmd;

    logic                    w_out_free, w_accept, w_full, w_found, w_dump_last;
    logic [IDXW-1:0]         w_ins_idx, w_del_idx;
    logic signed [KEY_W-1:0] w_del_key;
    logic [IDXW+POS_W-1:0]   w_ins_pos_x, w_del_pos_x;
    logic [CNTW+POS_W-1:0]   w_dump_pos_x;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CAPACITY-1:0] LowMask = {CAPACITY{1'b1}} >> (CAPACITY - g);
        t_entry w_left, w_right;

        assign w_before[g] = |(w_hit & LowMask);
        assign w_first[g]  = w_hit[g] & ~w_before[g];
        assign w_occ[g]    = w_ent[g].occ;

        if (g == 0) begin : g_head
            assign w_left   = '0;
            assign w_ins[g] = ~w_ge[g];
            assign w_ctl[g] = '{cmd: w_cmd, left_ge: 1'b1, hit_before: w_before[g]};
        end else begin : g_body
            assign w_left   = w_ent[g-1];
            assign w_ins[g] = ~w_ge[g] & w_ge[g-1];
            assign w_ctl[g] = '{cmd: w_cmd, left_ge: w_ge[g-1], hit_before: w_before[g]};
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_ent[g+1];
        end

        sli_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_key   (r_key),
            .i_id    (r_id),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_ent[0]),
            .o_entry (w_ent[g]),
            .o_ge    (w_ge[g]),
            .o_hit   (w_hit[g])
        );
    end

    // Insert point and first match each set at most one bit, so an OR encodes them.
    always_comb begin
        w_ins_idx = '0;
        w_del_idx = '0;
        w_del_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_ins[i]) begin
                w_ins_idx = w_ins_idx | IDXW'(i);
            end
            if (w_first[i]) begin
                w_del_idx = w_del_idx | IDXW'(i);
                w_del_key = w_del_key | w_ent[i].key;
            end
        end
    end

    assign w_ins_pos_x  = {{POS_W{1'b0}}, w_ins_idx};
    assign w_del_pos_x  = {{POS_W{1'b0}}, w_del_idx};
    assign w_dump_pos_x = {{POS_W{1'b0}}, r_dump_idx};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_full      = (r_count == CNTW'(CAPACITY));
    assign w_found     = |w_hit;
    assign w_dump_last = (CNTW'(r_dump_idx + 1'b1) == r_count);
    assign o_ready     = (r_state == S_IDLE) || ((r_state == S_EXEC) && w_out_free);
    assign w_accept    = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dump_idx = r_dump_idx;
        w_cmd      = CMD_HOLD;
        w_load     = 1'b0;
        n_status   = ST_DONE;
        n_out_key  = r_key;
        n_out_id   = r_id;
        n_pos      = '0;
        n_last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
            end
            S_CMP: begin
                w_cmd   = CMD_CMP;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (r_mode == MODE_INSERT) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_cmd   = CMD_INS;
                            n_count = r_count + 1'b1;
                            n_pos   = w_ins_pos_x[POS_W-1:0];
                        end
                    end else begin
                        if (w_found) begin
                            w_cmd     = CMD_DEL;
                            n_count   = r_count - 1'b1;
                            n_out_key = w_del_key;
                            n_pos     = w_del_pos_x[POS_W-1:0];
                        end else begin
                            n_status  = ST_NOT_FOUND;
                            n_out_key = '0;
                        end
                    end
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (r_count == '0) begin
                        n_status  = ST_EMPTY;
                        n_out_key = '0;
                        n_out_id  = '0;
                        n_state   = S_IDLE;
                    end else begin
                        w_cmd      = CMD_ROT;
                        n_out_key  = w_ent[0].key;
                        n_out_id   = w_ent[0].id;
                        n_pos      = w_dump_pos_x[POS_W-1:0];
                        n_last     = w_dump_last;
                        n_dump_idx = r_dump_idx + 1'b1;
                        if (w_dump_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_accept) begin
            n_dump_idx = '0;
            case (i_mode) inside
                MODE_INSERT, MODE_DELETE: n_state = S_CMP;
                MODE_DUMP:                n_state = S_DUMP;
                default:                  n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_idx <= n_dump_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_id   <= i_item_id;
        end
        if (w_load) begin
            r_status  <= n_status;
            r_out_key <= n_out_key;
            r_out_id  <= n_out_id;
            r_pos     <= n_pos;
            r_last    <= n_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_out_key  = r_out_key;
    assign o_out_id   = r_out_id;
    assign o_position = r_pos;
    assign o_last     = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_occ_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ) == int'(r_count))
        else $error("occupied cells disagree with entry count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_out_free && r_mode == MODE_INSERT && !w_full)
        |=> (r_count == CNTW'($past(r_count) + 1'b1)))
        else $error("accepted insert did not grow the list");

endmodule

FILE: design/sli_cell.sv
// ============================================================================
// sli_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast key and id, and on
// insert, delete or rotate takes the new entry, the head or a neighbor's entry.
// ============================================================================
module sli_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sli_pkg::t_cell_ctl              i_ctl,
    input  logic signed [sli_pkg::KEY_W-1:0] i_key,
    input  logic [sli_pkg::ID_W-1:0]        i_id,
    input  sli_pkg::t_entry                 i_left,
    input  sli_pkg::t_entry                 i_right,
    input  sli_pkg::t_entry                 i_head,
    output sli_pkg::t_entry                 o_entry,
    output logic                            o_ge,
    output logic                            o_hit
);
    import sli_pkg::*;

    logic                    r_occ, n_occ;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [ID_W-1:0]         r_id, n_id;
    logic                    r_ge, n_ge;
    logic                    r_hit, n_hit;

    always_comb begin
        n_occ = r_occ;
        n_key = r_key;
        n_id  = r_id;
        n_ge  = r_ge;
        n_hit = r_hit;
        case (i_ctl.cmd)
            CMD_CMP: begin
                n_ge  = r_occ && (r_key >= i_key);
                n_hit = r_occ && (r_id == i_id);
            end
            CMD_INS: begin
                if (!r_ge) begin
                    if (i_ctl.left_ge) begin
                        n_occ = 1'b1;
                        n_key = i_key;
                        n_id  = i_id;
                    end else begin
                        n_occ = i_left.occ;
                        n_key = i_left.key;
                        n_id  = i_left.id;
                    end
                end
            end
            CMD_DEL: begin
                if (i_ctl.hit_before || r_hit) begin
                    n_occ = i_right.occ;
                    n_key = i_right.key;
                    n_id  = i_right.id;
                end
            end
            CMD_ROT: begin
                // The occupied run rotates left by one; the head wraps to its end.
                if (r_occ) begin
                    if (i_right.occ) begin
                        n_key = i_right.key;
                        n_id  = i_right.id;
                    end else begin
                        n_key = i_head.key;
                        n_id  = i_head.id;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_ge  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_ge  <= n_ge;
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_id  <= n_id;
    end

    assign o_entry = '{occ: r_occ, key: r_key, id: r_id};
    assign o_ge    = r_ge;
    assign o_hit   = r_hit;

endmodule

FILE: verif/sorted_list_insert_delete_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// sorted_list_insert_delete_core_tb: self-checking bench for the sorted list
// A behavioral copy of the list predicts every result of each accepted item.
// Directed items cover the empty and full list, key and id extremes, equal
// keys, duplicate ids and the unused mode. Random traffic then runs under
// three idle patterns, with one long output stall to fill the block.
// ============================================================================
module sorted_list_insert_delete_core_tb;

    import sli_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int STALL_LIMIT      = 2000;
    localparam int SINK_HOLD_CYCLES = 120;

    localparam logic [MODE_W-1:0]       MODE_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic [ID_W-1:0]         ID_MAX      = {ID_W{1'b1}};

    typedef struct {
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
        logic [POS_W-1:0]        position;
        logic                    last;
    } t_list_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [MODE_W-1:0]       i_mode;
    logic signed [KEY_W-1:0] i_key;
    logic [ID_W-1:0]         i_item_id;
    logic                    o_valid;
    logic                    i_ready;
    logic [STATUS_W-1:0]     o_status;
    logic signed [KEY_W-1:0] o_out_key;
    logic [ID_W-1:0]         o_out_id;
    logic [POS_W-1:0]        o_position;
    logic                    o_last;

    // Behavioral copy of the list, head at index 0.
    logic signed [KEY_W-1:0] model_keys [CAPACITY];
    logic [ID_W-1:0]         model_ids  [CAPACITY];
    int                      model_count;

    t_list_result awaited_results[$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           sink_hold_request;

    sorted_list_insert_delete_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .i_key     (i_key),
        .i_item_id (i_item_id),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_status  (o_status),
        .o_out_key (o_out_key),
        .o_out_id  (o_out_id),
        .o_position(o_position),
        .o_last    (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one operation to the list copy and queues the results it causes.
    task automatic model_apply_op(input logic [MODE_W-1:0] mode,
                                  input logic signed [KEY_W-1:0] key,
                                  input logic [ID_W-1:0] id);
        int                      pos;
        int                      i;
        logic signed [KEY_W-1:0] gone_key;
        case (mode)
            MODE_INSERT: begin
                if (model_count >= CAPACITY) begin
                    awaited_results.push_back('{ST_FULL, key, id, 0, 1'b1});
                end else begin
                    pos = 0;
                    while (pos < model_count && model_keys[pos] >= key)
                        pos++;
                    for (i = model_count; i > pos; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_ids[i]  = model_ids[i-1];
                    end
                    model_keys[pos] = key;
                    model_ids[pos]  = id;
                    model_count++;
                    awaited_results.push_back('{ST_DONE, key, id, POS_W'(pos), 1'b1});
                end
            end
            MODE_DELETE: begin
                pos = 0;
                while (pos < model_count && model_ids[pos] != id)
                    pos++;
                if (pos >= model_count) begin
                    awaited_results.push_back('{ST_NOT_FOUND, 0, id, 0, 1'b1});
                end else begin
                    gone_key = model_keys[pos];
                    for (i = pos; i + 1 < model_count; i++) begin
                        model_keys[i] = model_keys[i+1];
                        model_ids[i]  = model_ids[i+1];
                    end
                    model_count--;
                    awaited_results.push_back('{ST_DONE, gone_key, id, POS_W'(pos), 1'b1});
                end
            end
            MODE_DUMP: begin
                if (model_count == 0) begin
                    awaited_results.push_back('{ST_EMPTY, 0, 0, 0, 1'b1});
                end else begin
                    for (i = 0; i < model_count; i++)
                        awaited_results.push_back('{ST_DONE, model_keys[i], model_ids[i],
                                                    POS_W'(i), i == model_count - 1});
                end
            end
            default: ;
        endcase
    endtask

    // Starts at a falling edge and returns right after the accepting rising edge.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic signed [KEY_W-1:0] key,
                             input logic [ID_W-1:0] id);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_key     <= key;
        i_item_id <= id;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        model_apply_op(mode, key, id);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9)) inside
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;  // many ties
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9)) inside
            0:       return ID_MAX;
            1:       return '0;
            2, 3, 4, 5, 6: return ID_W'($urandom_range(0, 11));  // small pool repeats ids
            default: return ID_W'($urandom());
        endcase
    endfunction

    task automatic check_field(input string name, input logic [KEY_W-1:0] expv,
                               input logic [KEY_W-1:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0h, got %0h", name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        t_list_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d key %0h id %0h position %0d",
                       o_status, o_out_key, o_out_id, o_position);
                error_count++;
            end else begin
                exp_res = awaited_results.pop_front();
                check_field("status", exp_res.status, o_status);
                check_field("out_key", exp_res.key, o_out_key);
                check_field("out_id", exp_res.id, o_out_id);
                check_field("position", exp_res.position, o_position);
                check_field("last", exp_res.last, o_last);
            end
        end
    end

    // Result receiver; a hold request drops ready for a long counted stretch.
    initial begin : result_sink
        int held;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                for (held = 0; held < SINK_HOLD_CYCLES; held++) begin
                    i_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** sorted_list_insert_delete_core: FAILED **");
        $finish;
    end

    task automatic test_empty_list();
        send_item(MODE_DUMP, 0, 0);
        send_item(MODE_DELETE, 0, 5);
        send_item(MODE_UNUSED, -1, ID_MAX);
    endtask

    task automatic test_key_extremes();
        send_item(MODE_INSERT, KEY_MAX, ID_MAX);
        send_item(MODE_INSERT, KEY_MIN, 0);
        send_item(MODE_INSERT, 0, 1);
        send_item(MODE_INSERT, -1, 2);
    endtask

    // New entries with an equal key go behind the ones already there.
    task automatic test_equal_keys();
        send_item(MODE_INSERT, 0, 3);
        send_item(MODE_INSERT, 0, 4);
    endtask

    task automatic test_delete();
        // Id 3 now appears twice; the delete must take the one nearer the head.
        send_item(MODE_INSERT, KEY_MIN, 3);
        send_item(MODE_DELETE, KEY_MAX, 3);
        send_item(MODE_DELETE, 0, ID_MAX);
        send_item(MODE_DELETE, 0, 0);
        send_item(MODE_DELETE, 0, 9);
    endtask

    task automatic test_full_list();
        while (model_count < CAPACITY)
            send_item(MODE_INSERT, pick_key(), pick_id());
        send_item(MODE_INSERT, KEY_MAX, ID_MAX);
        send_item(MODE_DUMP, 0, 0);
        send_item(MODE_UNUSED, KEY_MIN, 0);
    endtask

    // The sender keeps offering items while the receiver holds off.
    task automatic test_output_backpressure();
        int n;
        sink_hold_request = 1'b1;
        for (n = 0; n < 24; n++) begin
            if (n % 3 == 2 && model_count > 0)
                send_item(MODE_DELETE, 0, model_ids[$urandom_range(0, model_count - 1)]);
            else if (n % 8 == 7)
                send_item(MODE_DUMP, 0, 0);
            else
                send_item(MODE_INSERT, pick_key(), pick_id());
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int               n;
        int               sel;
        logic [ID_W-1:0]  id;
        n = 0;
        while (n < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_item(MODE_INSERT, pick_key(), pick_id());
            end else if (sel < 80) begin
                // Mostly delete an id that is present so the list keeps moving.
                if (model_count > 0 && $urandom_range(0, 3) != 0)
                    id = model_ids[$urandom_range(0, model_count - 1)];
                else
                    id = pick_id();
                send_item(MODE_DELETE, pick_key(), id);
            end else if (sel < 95) begin
                send_item(MODE_DUMP, pick_key(), pick_id());
            end else begin
                send_item(MODE_UNUSED, pick_key(), pick_id());
                n--;
            end
            n++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_mode            = MODE_INSERT;
        i_key             = '0;
        i_item_id         = '0;
        model_count       = 0;
        error_count       = 0;
        send_idle_pct     = 26;
        recv_idle_pct     = 54;
        sink_hold_request = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_key_extremes();
        test_equal_keys();
        test_delete();
        test_full_list();
        test_random_traffic(100);
        test_output_backpressure();
        wait_drained();

        send_idle_pct = 54;
        recv_idle_pct = 26;
        test_random_traffic(110);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(110);
        wait_drained();

        // Allow stray results to show before the verdict.
        repeat (3 * CAPACITY) @(posedge i_clk);
        if (error_count == 0)
            $display("** sorted_list_insert_delete_core: PASSED **");
        else
            $display("** sorted_list_insert_delete_core: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/sli_pkg.sv
design/sli_cell.sv
design/sorted_list_insert_delete_core.sv
verif/sorted_list_insert_delete_core_tb.sv
